>>> hw/rtl/vntv_pkg.sv
// ----------------------------------------------------------------------------
// vntv_pkg
// Shared types and constants of the value noise terrain voxel block.
// ----------------------------------------------------------------------------
package vntv_pkg;

  // voxel edge of one chunk, as a shift
  localparam int unsigned ChunkShift = 4;

  // world coordinate width: 16 bit chunk plus local offset
  localparam int unsigned WorldW = 16 + ChunkShift + 1;

  // noise coordinate width: world times unsigned 16 bit scale
  localparam int unsigned PosW = WorldW + 17;

  // hash multipliers
  localparam logic [31:0] MulX   = 32'd374761393;
  localparam logic [31:0] MulY   = 32'd668265263;
  localparam logic [31:0] MulFin = 32'd1274126177;

  // register reset values
  localparam logic [31:0] SeedRst  = 32'd0;
  localparam logic [15:0] ScaleRst = 16'd3277;
  localparam logic [7:0]  AmpRst   = 8'd8;
  localparam logic [20:0] BaseRst  = 21'sd32;

  // register indexes
  typedef enum logic [1:0] {
    RegSeed  = 2'd0,
    RegScale = 2'd1,
    RegAmp   = 2'd2,
    RegBase  = 2'd3
  } reg_idx_e;

  // terrain classes
  typedef enum logic [1:0] {
    KindAir   = 2'd0,
    KindStone = 2'd1,
    KindDirt  = 2'd2,
    KindGrass = 2'd3
  } kind_e;

  localparam logic [5:0] LightAir = 6'd63;
  localparam logic [5:0] LightSolid = 6'd0;

  // word passed from front to back
  typedef struct packed {
    logic [31:0] cell_x;
    logic [31:0] cell_z;
    logic [15:0] frac_x;
    logic [15:0] frac_z;
    logic signed [WorldW-1:0] world_y;
  } front_word_t;

  // config registers as seen by the datapath
  typedef struct packed {
    logic [31:0]        seed;
    logic [15:0]        scale;
    logic [7:0]         amp;
    logic signed [20:0] base;
  } cfg_t;

  // result word
  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         light;
    logic [15:0]        noise;
    logic signed [21:0] height;
  } result_t;

endpackage

>>> hw/rtl/vntv_front.sv
// ----------------------------------------------------------------------------
// vntv_front
// Forms world coordinates and splits x and z into lattice cell and fraction.
// ----------------------------------------------------------------------------
module vntv_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  stall_i,
  input  logic                  valid_i,
  input  logic signed [15:0]    chunk_x_i,
  input  logic signed [15:0]    chunk_y_i,
  input  logic signed [15:0]    chunk_z_i,
  input  logic [3:0]            local_x_i,
  input  logic [3:0]            local_y_i,
  input  logic [3:0]            local_z_i,
  input  logic [15:0]           scale_i,
  output logic                  valid_o,
  output vntv_pkg::front_word_t word_o
);

  localparam int unsigned Ww = vntv_pkg::WorldW;
  localparam int unsigned Pw = vntv_pkg::PosW;

  logic signed [Ww-1:0] wx_d, wy_d, wz_d, wx_q, wy_q, wz_q;
  logic                 v1_q, v2_q;
  logic signed [Pw-1:0] px, pz;
  vntv_pkg::front_word_t word_q;

  // world coordinates
  always_comb begin
    wx_d = (Ww'(chunk_x_i) <<< vntv_pkg::ChunkShift) + Ww'({1'b0, local_x_i});
    wy_d = (Ww'(chunk_y_i) <<< vntv_pkg::ChunkShift) + Ww'({1'b0, local_y_i});
    wz_d = (Ww'(chunk_z_i) <<< vntv_pkg::ChunkShift) + Ww'({1'b0, local_z_i});
  end

  // scaled positions
  assign px = Pw'(wx_q) * $signed({1'b0, scale_i});
  assign pz = Pw'(wz_q) * $signed({1'b0, scale_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (!stall_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      wx_q <= wx_d;
      wy_q <= wy_d;
      wz_q <= wz_d;
      word_q.cell_x  <= 32'(px >>> 16);
      word_q.cell_z  <= 32'(pz >>> 16);
      word_q.frac_x  <= px[15:0];
      word_q.frac_z  <= pz[15:0];
      word_q.world_y <= wy_q;
    end
  end

  assign valid_o = v2_q;
  assign word_o  = word_q;

endmodule

>>> hw/rtl/vntv_queue.sv
// ----------------------------------------------------------------------------
// vntv_queue
// Small queue between the front and the back of the voxel pipeline.
// ----------------------------------------------------------------------------
module vntv_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  vntv_pkg::front_word_t wdata_i,
  input  logic                  pop_i,
  output logic                  empty_o,
  output logic [2:0]            count_o,
  output vntv_pkg::front_word_t rdata_o
);

  vntv_pkg::front_word_t mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 2'd1;
      if (pop_i) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rp_q];
  assign empty_o = (cnt_q == 3'd0);
  assign count_o = cnt_q;

endmodule

>>> hw/rtl/vntv_back.sv
// ----------------------------------------------------------------------------
// vntv_back
// Hashes lattice corners, blends them and classifies the voxel.
// ----------------------------------------------------------------------------
module vntv_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  stall_i,
  input  logic                  valid_i,
  input  vntv_pkg::front_word_t word_i,
  input  vntv_pkg::cfg_t        cfg_i,
  output logic                  valid_o,
  output vntv_pkg::result_t     res_o
);

  localparam int unsigned Ww = vntv_pkg::WorldW;
  localparam int Depth = 9;

  logic [Depth-1:0] v_q;

  // stage 1: per-axis products and smoothstep square
  logic [31:0] mx0_q, mx1_q, mz0_q, mz1_q;
  logic [15:0] fx1_q, fz1_q, qx_q, qz_q;
  logic signed [Ww-1:0] y1_q;
  // stage 2: corner premix and smoothstep
  logic [31:0] h_q [4];
  logic [15:0] sx2_q, sz2_q;
  logic signed [Ww-1:0] y2_q;
  // stage 3: final multiply
  logic [31:0] g_q [4];
  logic [15:0] sx3_q, sz3_q;
  logic signed [Ww-1:0] y3_q;
  // stage 4: corner values
  logic [15:0] c_q [4];
  logic [15:0] sx4_q, sz4_q;
  logic signed [Ww-1:0] y4_q;
  // stage 5: row products
  logic [32:0] pa_q [4];
  logic [15:0] sz5_q;
  logic signed [Ww-1:0] y5_q;
  // stage 6: row sums
  logic [15:0] r0_q, r1_q, sz6_q;
  logic signed [Ww-1:0] y6_q;
  // stage 7: column products
  logic [32:0] pb0_q, pb1_q;
  logic signed [Ww-1:0] y7_q;
  // stage 8: noise and scaled height
  logic [15:0] n8_q;
  logic [23:0] na8_q;
  logic signed [Ww-1:0] y8_q;
  // stage 9: result
  vntv_pkg::result_t res_q;

  logic [31:0] hm [4];
  logic [31:0] sm [2];
  logic [16:0] sm_arg [2];
  logic [31:0] gm [4];
  logic signed [37:0] total;
  logic signed [21:0] hgt;
  logic signed [22:0] wy_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (!stall_i) v_q <= {v_q[Depth-2:0], valid_i};
  end

  // corner premix
  always_comb begin
    hm[0] = cfg_i.seed ^ mx0_q ^ mz0_q;
    hm[1] = cfg_i.seed ^ mx1_q ^ mz0_q;
    hm[2] = cfg_i.seed ^ mx0_q ^ mz1_q;
    hm[3] = cfg_i.seed ^ mx1_q ^ mz1_q;
    sm_arg[0] = 17'd98304 - {1'b0, fx1_q};
    sm_arg[1] = 17'd98304 - {1'b0, fz1_q};
    sm[0] = 32'(qx_q) * 32'(sm_arg[0]);
    sm[1] = 32'(qz_q) * 32'(sm_arg[1]);
    for (int i = 0; i < 4; i++) gm[i] = h_q[i] * vntv_pkg::MulFin;
  end

  // height and class
  always_comb begin
    total = (38'(cfg_i.base) <<< 16) + 38'($signed({1'b0, na8_q}));
    hgt   = 22'((total < 0) ? -((-total) >>> 16) : (total >>> 16));
    wy_e  = 23'(y8_q);
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      mx0_q <= word_i.cell_x * vntv_pkg::MulX;
      mx1_q <= (word_i.cell_x + 32'd1) * vntv_pkg::MulX;
      mz0_q <= word_i.cell_z * vntv_pkg::MulY;
      mz1_q <= (word_i.cell_z + 32'd1) * vntv_pkg::MulY;
      fx1_q <= word_i.frac_x;
      fz1_q <= word_i.frac_z;
      qx_q  <= 16'((32'(word_i.frac_x) * 32'(word_i.frac_x)) >> 16);
      qz_q  <= 16'((32'(word_i.frac_z) * 32'(word_i.frac_z)) >> 16);
      y1_q  <= word_i.world_y;

      for (int i = 0; i < 4; i++) h_q[i] <= hm[i] ^ (hm[i] >> 13);
      // smooth = q*(196608-2f)>>16 = q*(98304-f)>>15
      sx2_q <= 16'(sm[0] >> 15);
      sz2_q <= 16'(sm[1] >> 15);
      y2_q  <= y1_q;

      for (int i = 0; i < 4; i++) g_q[i] <= gm[i];
      sx3_q <= sx2_q;
      sz3_q <= sz2_q;
      y3_q  <= y2_q;

      for (int i = 0; i < 4; i++) c_q[i] <= g_q[i][15:0] ^ g_q[i][31:16];
      sx4_q <= sx3_q;
      sz4_q <= sz3_q;
      y4_q  <= y3_q;

      pa_q[0] <= 33'(c_q[0]) * (33'd65536 - 33'(sx4_q));
      pa_q[1] <= 33'(c_q[1]) * 33'(sx4_q);
      pa_q[2] <= 33'(c_q[2]) * (33'd65536 - 33'(sx4_q));
      pa_q[3] <= 33'(c_q[3]) * 33'(sx4_q);
      sz5_q <= sz4_q;
      y5_q  <= y4_q;

      r0_q  <= 16'((pa_q[0] + pa_q[1]) >> 16);
      r1_q  <= 16'((pa_q[2] + pa_q[3]) >> 16);
      sz6_q <= sz5_q;
      y6_q  <= y5_q;

      pb0_q <= 33'(r0_q) * (33'd65536 - 33'(sz6_q));
      pb1_q <= 33'(r1_q) * 33'(sz6_q);
      y7_q  <= y6_q;

      n8_q  <= 16'((pb0_q + pb1_q) >> 16);
      na8_q <= 24'(16'((pb0_q + pb1_q) >> 16)) * 24'(cfg_i.amp);
      y8_q  <= y7_q;

      res_q.noise  <= n8_q;
      res_q.height <= hgt;
      if (wy_e < 23'(hgt) - 23'sd3) begin
        res_q.kind  <= vntv_pkg::KindStone;
        res_q.light <= vntv_pkg::LightSolid;
      end else if (wy_e < 23'(hgt) - 23'sd1) begin
        res_q.kind  <= vntv_pkg::KindDirt;
        res_q.light <= vntv_pkg::LightSolid;
      end else if (wy_e < 23'(hgt)) begin
        res_q.kind  <= vntv_pkg::KindGrass;
        res_q.light <= vntv_pkg::LightSolid;
      end else begin
        res_q.kind  <= vntv_pkg::KindAir;
        res_q.light <= vntv_pkg::LightAir;
      end
    end
  end

  assign valid_o = v_q[Depth-1];
  assign res_o   = res_q;

endmodule

>>> hw/rtl/value_noise_terrain_voxel.sv
// Path: from accept to the word on the result ports through the front stages,
// the middle queue, the back stages and the output queue write.
// Throughput: one voxel per cycle while full is low; the hash and blend
// pipelines are fully pipelined. Output queue of 16 words; input is held off
// once queued plus in flight work could overflow it.
// Reset: asynchronous active low, clears pipeline valids, queues and registers.
// ----------------------------------------------------------------------------
// value_noise_terrain_voxel
// Classifies voxels against a hashed value noise height field.
// ----------------------------------------------------------------------------
module value_noise_terrain_voxel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] chunk_x_i,
  input  logic signed [15:0] chunk_y_i,
  input  logic signed [15:0] chunk_z_i,
  input  logic [3:0]         local_x_i,
  input  logic [3:0]         local_y_i,
  input  logic [3:0]         local_z_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         block_kind_o,
  output logic [5:0]         light_level_o,
  output logic [15:0]        noise_value_o,
  output logic signed [21:0] surface_height_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  vntv_pkg::cfg_t cfg_q;
  logic [1:0] ridx;
  logic       cfg_we;

  // config registers
  assign pready = 1'b1;
  assign ridx   = paddr[3:2];
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed  <= vntv_pkg::SeedRst;
      cfg_q.scale <= vntv_pkg::ScaleRst;
      cfg_q.amp   <= vntv_pkg::AmpRst;
      cfg_q.base  <= vntv_pkg::BaseRst;
    end else if (cfg_we) begin
      case (vntv_pkg::reg_idx_e'(ridx))
        vntv_pkg::RegSeed:  cfg_q.seed  <= pwdata;
        vntv_pkg::RegScale: cfg_q.scale <= pwdata[15:0];
        vntv_pkg::RegAmp:   cfg_q.amp   <= pwdata[7:0];
        vntv_pkg::RegBase:  cfg_q.base  <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (vntv_pkg::reg_idx_e'(ridx))
      vntv_pkg::RegSeed:  prdata = cfg_q.seed;
      vntv_pkg::RegScale: prdata = {16'd0, cfg_q.scale};
      vntv_pkg::RegAmp:   prdata = {24'd0, cfg_q.amp};
      vntv_pkg::RegBase:  prdata = 32'(cfg_q.base);
      default:            prdata = '0;
    endcase
  end

  // front: world coords and cell split, never stalls
  logic                  fv;
  vntv_pkg::front_word_t fw, qw;
  logic                  q_empty;
  logic [2:0]            q_cnt;
  logic                  accept;

  vntv_front u_front (
    .clk_i, .rst_ni,
    .stall_i   (1'b0),
    .valid_i   (accept),
    .chunk_x_i, .chunk_y_i, .chunk_z_i,
    .local_x_i, .local_y_i, .local_z_i,
    .scale_i   (cfg_q.scale),
    .valid_o   (fv),
    .word_o    (fw)
  );

  // back runs freely; credit on the output queue gates input
  logic              bv;
  vntv_pkg::result_t br;
  logic              q_pop;

  assign q_pop = !q_empty;

  vntv_queue u_mid (
    .clk_i, .rst_ni,
    .push_i  (fv),
    .wdata_i (fw),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .count_o (q_cnt),
    .rdata_o (qw)
  );

  vntv_back u_back (
    .clk_i, .rst_ni,
    .stall_i (1'b0),
    .valid_i (q_pop),
    .word_i  (qw),
    .cfg_i   (cfg_q),
    .valid_o (bv),
    .res_o   (br)
  );

  // output queue with credit count over everything in flight
  vntv_pkg::result_t oq_q [16];
  logic [3:0] owp_q, orp_q;
  logic [4:0] ocnt_q;
  logic [4:0] inflight_q;
  logic       opop;

  assign opop   = pop && !empty;
  assign full   = (5'(ocnt_q) + inflight_q) >= 5'd16;
  assign accept = push && !full;
  assign empty  = (ocnt_q == 5'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q      <= '0;
      orp_q      <= '0;
      ocnt_q     <= '0;
      inflight_q <= '0;
    end else begin
      if (bv) owp_q <= owp_q + 4'd1;
      if (opop) orp_q <= orp_q + 4'd1;
      ocnt_q     <= ocnt_q + 5'(bv) - 5'(opop);
      inflight_q <= inflight_q + 5'(accept) - 5'(bv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (bv) oq_q[owp_q] <= br;
  end

  assign block_kind_o     = oq_q[orp_q].kind;
  assign light_level_o    = oq_q[orp_q].light;
  assign noise_value_o    = oq_q[orp_q].noise;
  assign surface_height_o = oq_q[orp_q].height;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q + inflight_q) <= 5'd16) else $error("output credit overflow");
  a_mid_small: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= 3'd1) else $error("middle queue backs up");
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty |-> !opop) else $error("pop on empty");
`endif

endmodule

>>> tb/vntv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vntv_checker
// Watches the voxel and result channels and the register port, predicts the
// terrain class, light, column noise and surface height of every voxel and
// compares each popped word with the oldest prediction.
// ----------------------------------------------------------------------------
module vntv_checker
  import vntv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               full_i,
  input  logic signed [15:0] chunk_x_i,
  input  logic signed [15:0] chunk_y_i,
  input  logic signed [15:0] chunk_z_i,
  input  logic [3:0]         local_x_i,
  input  logic [3:0]         local_y_i,
  input  logic [3:0]         local_z_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [1:0]         block_kind_i,
  input  logic [5:0]         light_level_i,
  input  logic [15:0]        noise_value_i,
  input  logic signed [21:0] surface_height_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [3:0]         paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam longint unsigned HashZMul = 64'd2147483647;

  logic [31:0]        seed_q;
  logic [15:0]        scale_q;
  logic [7:0]         amp_q;
  logic signed [20:0] base_q;
  result_t            terrain_q[$];

  assign pending_o = terrain_q.size();

  function automatic logic [15:0] corner_value(logic [31:0] cx, logic [31:0] cz);
    logic [31:0] h;
    h = seed_q;
    h ^= 32'(cx * MulX);
    h ^= 32'(cz * MulY);
    h ^= 32'(32'd0 * HashZMul);
    h = 32'((h ^ (h >> 13)) * MulFin);
    h ^= h >> 16;
    return h[15:0];
  endfunction

  function automatic longint unsigned fade(longint unsigned f);
    longint unsigned q;
    q = (f * f) >> 16;
    return (q * (64'd196608 - 2 * f)) >> 16;
  endfunction

  function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
                                          longint unsigned s);
    return (a * (64'd65536 - s) + b * s) >> 16;
  endfunction

  function automatic result_t classify(logic signed [15:0] chx, logic signed [15:0] chy,
                                       logic signed [15:0] chz, logic [3:0] lx,
                                       logic [3:0] ly, logic [3:0] lz);
    longint wx, wy, wz, px, pz, total, hgt;
    longint unsigned fx, fz, sx, sz, r0, r1, n;
    logic [31:0] ix, iz;
    result_t r;
    wx = longint'(chx) * 16 + longint'(lx);
    wy = longint'(chy) * 16 + longint'(ly);
    wz = longint'(chz) * 16 + longint'(lz);
    px = wx * longint'(scale_q);
    pz = wz * longint'(scale_q);
    fx = px & 64'hFFFF;
    fz = pz & 64'hFFFF;
    ix = 32'((px - longint'(fx)) / 65536);
    iz = 32'((pz - longint'(fz)) / 65536);
    sx = fade(fx);
    sz = fade(fz);
    r0 = mix(corner_value(ix, iz), corner_value(ix + 1, iz), sx);
    r1 = mix(corner_value(ix, iz + 1), corner_value(ix + 1, iz + 1), sx);
    n = mix(r0, r1, sz);
    total = longint'(base_q) * 65536 + longint'(n * amp_q);
    hgt = total / 65536;
    r.noise = n[15:0];
    r.height = hgt[21:0];
    if (wy < hgt - 3) begin
      r.kind = KindStone;
    end else if (wy < hgt - 1) begin
      r.kind = KindDirt;
    end else if (wy < hgt) begin
      r.kind = KindGrass;
    end else begin
      r.kind = KindAir;
    end
    r.light = (r.kind == KindAir) ? LightAir : LightSolid;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  // register writes, voxel predictions and result compares
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      seed_q <= SeedRst;
      scale_q <= ScaleRst;
      amp_q <= AmpRst;
      base_q <= BaseRst;
      terrain_q.delete();
      errors_o = 0;
    end else begin
      if (push_i && !full_i) begin
        terrain_q.push_back(classify(chunk_x_i, chunk_y_i, chunk_z_i,
                                     local_x_i, local_y_i, local_z_i));
      end
      if (pop_i && !empty_i) begin
        if (terrain_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = terrain_q.pop_front();
          if (block_kind_i != want.kind) report_mismatch("kind", block_kind_i, want.kind);
          if (light_level_i != want.light) report_mismatch("light", light_level_i, want.light);
          if (noise_value_i != want.noise) report_mismatch("noise", noise_value_i, want.noise);
          if (surface_height_i != want.height)
            report_mismatch("height", surface_height_i, want.height);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          RegSeed:  seed_q <= pwdata_i;
          RegScale: scale_q <= pwdata_i[15:0];
          RegAmp:   amp_q <= pwdata_i[7:0];
          RegBase:  base_q <= pwdata_i[20:0];
          default:  ;
        endcase
      end
    end
  end

endmodule

>>> tb/tb_value_noise_terrain_voxel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_terrain_voxel
// Streams directed and random voxels through the terrain block under several
// register settings with random idle bursts on both sides, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_value_noise_terrain_voxel;
  import vntv_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] chunk_x_i = '0, chunk_y_i = '0, chunk_z_i = '0;
  logic [3:0]         local_x_i = '0, local_y_i = '0, local_z_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         block_kind_o;
  logic [5:0]         light_level_o;
  logic [15:0]        noise_value_o;
  logic signed [21:0] surface_height_o;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  int                 errors, pending;
  bit                 calm = 1'b0;

  always #5 clk_i = ~clk_i;

  value_noise_terrain_voxel dut (.*);

  vntv_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full),
    .chunk_x_i, .chunk_y_i, .chunk_z_i, .local_x_i, .local_y_i, .local_z_i,
    .empty_i(empty), .pop_i(pop), .block_kind_i(block_kind_o),
    .light_level_i(light_level_o), .noise_value_i(noise_value_o),
    .surface_height_i(surface_height_o), .psel_i(psel), .penable_i(penable),
    .pwrite_i(pwrite), .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .errors_o(errors), .pending_o(pending)
  );

  // result side: pop with random stall bursts
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 4);
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one voxel; push stays high into the next call when no idle burst follows
  task automatic send_voxel(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                            logic [3:0] lx, logic [3:0] ly, logic [3:0] lz);
    chunk_x_i <= cx; chunk_y_i <= cy; chunk_z_i <= cz;
    local_x_i <= lx; local_y_i <= ly; local_z_i <= lz;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_random();
    logic [15:0] cx, cz, cy;
    cx = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
    cz = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40) - 20);
    // keep most voxels near the surface so every class shows up
    cy = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 6) - 1);
    send_voxel(cx, cy, cz, 4'($urandom), 4'($urandom), 4'($urandom));
  endtask

  // called at a falling edge: drop push before the next rising edge
  task automatic drain();
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  // stimulus and verdict
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed at reset settings: field extremes
    send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'hF, 4'hF, 4'hF);
    send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 4'h0, 4'h0, 4'h0);
    send_voxel(16'h0000, 16'h0001, 16'h0000, 4'h0, 4'h0, 4'h0);
    send_voxel(16'hFFFF, 16'hFFFF, 16'hFFFF, 4'hF, 4'hF, 4'hF);
    for (int y = 0; y < 4; y++) send_voxel(16'h0003, 16'h0002, 16'h0005, 4'h7, 4'(y * 4 + 3), 4'h9);
    for (int i = 0; i < 6; i++) send_voxel(16'h0, 16'h2, 16'h0, 4'(i), 4'(i * 3), 4'(i));
    drain();
    // zero scale, zero amplitude
    write_reg(RegScale, 32'h0);
    write_reg(RegAmp, 32'h0);
    for (int i = 0; i < 6; i++) send_voxel(16'(i * 999), 16'h2, 16'(-i), 4'(i), 4'(i * 2), 4'(i));
    drain();
    // maximum scale, amplitude, seed and base extremes
    write_reg(RegScale, 32'hFFFF);
    write_reg(RegAmp, 32'hFF);
    write_reg(RegSeed, 32'hFFFF_FFFF);
    write_reg(RegBase, 32'h000F_FFFF);
    send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'hF, 4'hF, 4'hF);
    send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 4'h0, 4'h0, 4'h0);
    drain();
    write_reg(RegBase, 32'h0010_0000);
    send_voxel(16'sh8000, 16'sh8000, 16'sh8000, 4'h0, 4'h0, 4'h0);
    send_voxel(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 4'hF, 4'hF, 4'hF);
    drain();
    // random phases under random settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegSeed, $urandom);
      write_reg(RegScale, $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(500, 9000));
      write_reg(RegAmp, $urandom_range(0, 255));
      write_reg(RegBase, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 80) - 10);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 105; i++) send_random();
      drain();
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
